// ===== hw/rtl/fldmp_pkg.sv =====
`default_nettype none

package fldmp_pkg;

	localparam int TAG_W  = 8;
	localparam int SIZE_W = 2;
	localparam int ADDR_W = 32;
	localparam int DATA_W = 32;
	localparam int LEFT_W = 4;
	localparam int LANES  = 4;

	// access size codes
	localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
	localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;
	localparam logic [SIZE_W-1:0] SIZE_BAD  = 2'd3;

	localparam logic [DATA_W-1:0] MASK_BYTE = 32'h0000_00ff;
	localparam logic [DATA_W-1:0] MASK_HALF = 32'h0000_ffff;
	localparam logic [DATA_W-1:0] MASK_WORD = 32'hffff_ffff;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              st_op;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] store_data;
	} held_t;

	// sequencer to datapath
	typedef struct packed {
		logic issue;
		logic step;
		logic clr_active;
		logic complete;
		logic accept;
		logic busy_next;
	} ctl_t;

	function automatic logic [2:0] size_bytes(input logic [SIZE_W-1:0] size);
		logic [2:0] n;
		unique case (size)
			SIZE_BYTE: n = 3'd1;
			SIZE_HALF: n = 3'd2;
			SIZE_WORD: n = 3'd4;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [DATA_W-1:0] load_mask(input logic [SIZE_W-1:0] size);
		logic [DATA_W-1:0] m;
		unique case (size)
			SIZE_BYTE: m = MASK_BYTE;
			SIZE_HALF: m = MASK_HALF;
			SIZE_WORD: m = MASK_WORD;
			default:   m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fldmp_bank.sv =====
`default_nettype none

module fldmp_bank
	#(
	parameter int ROWS  = 16384,
	parameter int ROW_W = 14
	)
	(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [ROW_W-1:0] wrow,
	input  wire logic [7:0]       wdata,
	input  wire logic             re,
	input  wire logic [ROW_W-1:0] ra_row,
	input  wire logic [ROW_W-1:0] rb_row,
	output logic      [7:0]       ra_data,
	output logic      [7:0]       rb_data
	);

	// one byte lane, one write port and two registered read ports
	logic [7:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wrow] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			ra_data <= mem[ra_row];
			rb_data <= mem[rb_row];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fldmp_ctrl.sv =====
`default_nettype none

module fldmp_ctrl
	import fldmp_pkg::*;
	#(
	parameter int ROWS    = 16384,
	parameter int ROW_W   = 14,
	parameter int LATENCY = 2
	)
	(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             take_req,
	input  wire held_t            new_req,
	output logic                  busy,
	output ctl_t                  ctl,
	output held_t                 held,
	output logic      [ROW_W-1:0] clr_row
	);

	logic              clr_q;
	logic [ROW_W-1:0]  clr_row_q;
	logic              s1_q;
	logic              tbusy_q;
	logic [LEFT_W-1:0] left_q;
	held_t             held_q;

	assign busy = clr_q | s1_q;

	always_comb begin
		ctl.issue      = start & ~busy;
		ctl.step       = s1_q;
		ctl.clr_active = clr_q;
		ctl.complete   = tbusy_q & (left_q <= LEFT_W'(1));
		ctl.accept     = ~tbusy_q & take_req;
		ctl.busy_next  = ctl.accept | (tbusy_q & ~ctl.complete);
	end

	assign held    = held_q;
	assign clr_row = clr_row_q;

	// clearing sweep after reset, zeroing every row in turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			if (clr_row_q == ROW_W'(ROWS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_row_q <= clr_row_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= 1'b0;
		end else begin
			s1_q <= ctl.issue;
		end
	end

	// port state, advanced once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbusy_q <= 1'b0;
			left_q  <= '0;
		end else if (ctl.step) begin
			if (tbusy_q) begin
				if (ctl.complete) begin
					tbusy_q <= 1'b0;
					left_q  <= '0;
				end else begin
					left_q <= left_q - LEFT_W'(1);
				end
			end else if (ctl.accept) begin
				tbusy_q <= 1'b1;
				left_q  <= LEFT_W'(LATENCY);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && ctl.accept) begin
			held_q <= new_req;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_latency_data_memory_port.sv =====
// fixed latency data memory port with a same-transaction instruction fetch
//
// input channel: start/busy; a transaction is taken at a clock edge with start
// high and busy low. one transaction is one tick of the port: it carries the
// fetch request and an optional data request (req_valid with req_tag_valid).
// result channel: done strobes for one cycle with all result fields; the
// receiver cannot hold it off.
// done is registered from the step state that follows the accepting edge;
// busy is high for one cycle, so no new transaction is taken before the step.
// the byte lane memories are read at the accepting edge, written back in the step.
// a data request finishes LATENCY transactions after the one that took it;
// loads and stores are little endian, unaligned, and split over four lanes.
// the fetch sees memory as it stood before that transaction's store.
// reset: port idle, no response pending; busy then stays high while a
// sweep zeroes every memory row.
`default_nettype none

module fixed_latency_data_memory_port
	import fldmp_pkg::*;
	#(
	parameter int MEM_BYTES = 65536,
	parameter int LATENCY   = 2
	)
	(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              fetch_valid,
	input  wire logic [ADDR_W-1:0] fetch_address,
	input  wire logic              req_valid,
	input  wire logic              req_tag_valid,
	input  wire logic [TAG_W-1:0]  req_tag,
	input  wire logic              req_is_store,
	input  wire logic [SIZE_W-1:0] req_size,
	input  wire logic [ADDR_W-1:0] req_address,
	input  wire logic [DATA_W-1:0] req_store_data,
	output logic                   done,
	output logic                   accepted,
	output logic                   port_free,
	output logic                   resp_valid,
	output logic      [TAG_W-1:0]  resp_tag,
	output logic                   resp_is_store,
	output logic                   resp_ok,
	output logic      [DATA_W-1:0] resp_load_data,
	output logic                   fetch_resp_valid,
	output logic                   fetch_ok,
	output logic      [DATA_W-1:0] fetch_word
	);

	// rows of four byte lanes
	localparam int ROWS  = (MEM_BYTES + LANES - 1) / LANES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	ctl_t             ctl;
	held_t            held;
	held_t            new_req_s1;
	logic             take_s1;
	logic             fvalid_s1;
	logic [ADDR_W-1:0] faddr_s1;
	logic [ROW_W-1:0] clr_row;

	logic [7:0]       f_byte [LANES];
	logic [7:0]       d_byte [LANES];
	logic [ROW_W-1:0] f_row  [LANES];
	logic [ROW_W-1:0] d_row  [LANES];
	logic             st_en  [LANES];
	logic [7:0]       st_byte [LANES];

	logic [2:0]        d_n;
	logic              d_ok;
	logic              f_ok;
	logic [DATA_W-1:0] f_raw;
	logic [DATA_W-1:0] d_raw;
	logic              do_store;

	// the sequencer owns reset sweep, handshake and the in-flight request
	fldmp_ctrl #(
		.ROWS    (ROWS),
		.ROW_W   (ROW_W),
		.LATENCY (LATENCY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.take_req (take_s1),
		.new_req  (new_req_s1),
		.busy     (busy),
		.ctl      (ctl),
		.held     (held),
		.clr_row  (clr_row)
	);

	// capture the transaction at the accepting edge
	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			fvalid_s1             <= fetch_valid;
			faddr_s1              <= fetch_address;
			take_s1               <= req_valid & req_tag_valid;
			new_req_s1.tag        <= req_tag;
			new_req_s1.st_op      <= req_is_store;
			new_req_s1.size       <= req_size;
			new_req_s1.address    <= req_address;
			new_req_s1.store_data <= req_store_data;
		end
	end

	// bounds: the whole span must lie below MEM_BYTES
	always_comb begin
		d_n  = size_bytes(held.size);
		d_ok = (d_n != 3'd0) &&
			(({1'b0, held.address} + 33'(d_n)) <= 33'(MEM_BYTES));
		f_ok = fvalid_s1 && (({1'b0, faddr_s1} + 33'(LANES)) <= 33'(MEM_BYTES));
		do_store = ctl.complete & held.st_op & d_ok;
	end

	// lane b holds byte b of a row; an unaligned access wraps to the next row
	// for the lanes below its start offset
	for (genvar b = 0; b < LANES; b++) begin : g_lane
		always_comb begin
			f_row[b] = fetch_address[ROW_W+1:2] +
				ROW_W'(2'(b) < fetch_address[1:0]);
			d_row[b] = held.address[ROW_W+1:2] +
				ROW_W'(2'(b) < held.address[1:0]);
			st_en[b]   = 3'(2'(2'(b) - held.address[1:0])) < d_n;
			st_byte[b] = held.store_data[8*(2'(2'(b) - held.address[1:0])) +: 8];
		end

		fldmp_bank #(
			.ROWS  (ROWS),
			.ROW_W (ROW_W)
		) u_bank (
			.clk     (clk),
			.we      (ctl.clr_active | (ctl.step & do_store & st_en[b])),
			.wrow    (ctl.clr_active ? clr_row : d_row[b]),
			.wdata   (ctl.clr_active ? 8'h00 : st_byte[b]),
			.re      (ctl.issue),
			.ra_row  (f_row[b]),
			.rb_row  (d_row[b]),
			.ra_data (f_byte[b]),
			.rb_data (d_byte[b])
		);
	end

	// put lane bytes back in little-endian order
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			f_raw[8*i +: 8] = f_byte[2'(faddr_s1[1:0] + 2'(i))];
			d_raw[8*i +: 8] = d_byte[2'(held.address[1:0] + 2'(i))];
		end
	end

	// result registers, loaded as the transaction ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.step;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			accepted         <= ctl.accept;
			port_free        <= ~ctl.busy_next;
			resp_valid       <= ctl.complete;
			resp_tag         <= ctl.complete ? held.tag : '0;
			resp_is_store    <= ctl.complete & held.st_op;
			resp_ok          <= ctl.complete & d_ok;
			resp_load_data   <= (ctl.complete && !held.st_op && d_ok) ?
				(d_raw & load_mask(held.size)) : '0;
			fetch_resp_valid <= fvalid_s1;
			fetch_ok         <= f_ok;
			fetch_word       <= f_ok ? f_raw : '0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fldmp_chk.sv =====
`default_nettype none

module fldmp_chk
	import fldmp_pkg::*;
	(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic              accepted,
	input wire logic              port_free,
	input wire logic              resp_valid,
	input wire logic              fetch_resp_valid,
	input wire logic              fetch_ok,
	input wire logic [DATA_W-1:0] fetch_word
	);

	// a taken transaction raises done after its step state
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("done missing two cycles after accept");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// no new request in the completing transaction
	a_no_accept_on_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && resp_valid) |-> !accepted)
		else $error("request taken while a response completes");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> !port_free)
		else $error("port free right after taking a request");

	a_fetch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !fetch_resp_valid) |-> (!fetch_ok && fetch_word == '0))
		else $error("fetch result without a fetch request");

endmodule

bind fixed_latency_data_memory_port fldmp_chk u_chk (.*);

`default_nettype wire

// ===== verif/data_port_checker.sv =====
`timescale 1ns / 100ps

// watches both channels of the memory port, predicts every transaction and
// compares the result strobe against the oldest prediction
module data_port_checker
	import fldmp_pkg::*;
	#(
	parameter int MEM_BYTES = 65536,
	parameter int LATENCY   = 2
	)
	(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              fetch_valid,
	input  wire logic [ADDR_W-1:0] fetch_address,
	input  wire logic              req_valid,
	input  wire logic              req_tag_valid,
	input  wire logic [TAG_W-1:0]  req_tag,
	input  wire logic              req_is_store,
	input  wire logic [SIZE_W-1:0] req_size,
	input  wire logic [ADDR_W-1:0] req_address,
	input  wire logic [DATA_W-1:0] req_store_data,
	input  wire logic              done,
	input  wire logic              accepted,
	input  wire logic              port_free,
	input  wire logic              resp_valid,
	input  wire logic [TAG_W-1:0]  resp_tag,
	input  wire logic              resp_is_store,
	input  wire logic              resp_ok,
	input  wire logic [DATA_W-1:0] resp_load_data,
	input  wire logic              fetch_resp_valid,
	input  wire logic              fetch_ok,
	input  wire logic [DATA_W-1:0] fetch_word,
	output int                     mismatches,
	output int                     outstanding
	);

	typedef struct packed {
		logic              accepted;
		logic              port_free;
		logic              resp_valid;
		logic [TAG_W-1:0]  resp_tag;
		logic              resp_is_store;
		logic              resp_ok;
		logic [DATA_W-1:0] resp_load_data;
		logic              fetch_resp_valid;
		logic              fetch_ok;
		logic [DATA_W-1:0] fetch_word;
	} port_tick_t;

	// shadow of the port: memory image, in-flight request and its countdown
	logic [7:0]  mem_image [MEM_BYTES];
	logic        in_flight;
	int unsigned ticks_left;
	held_t       pending_req;

	port_tick_t  expected_ticks [$];

	function automatic int unsigned access_bytes(input logic [SIZE_W-1:0] size);
		case (size)
			SIZE_BYTE: return 1;
			SIZE_HALF: return 2;
			SIZE_WORD: return 4;
			default:   return 0;
		endcase
	endfunction

	function automatic logic fits_in_memory(input logic [ADDR_W-1:0] addr, input int unsigned n);
		return ({32'd0, addr} + 64'(n)) <= 64'(MEM_BYTES);
	endfunction

	function automatic logic [DATA_W-1:0] read_bytes(input logic [ADDR_W-1:0] addr,
			input int unsigned n);
		logic [DATA_W-1:0] v;
		v = '0;
		for (int unsigned i = 0; i < n; i++) begin
			v |= DATA_W'(mem_image[(addr + ADDR_W'(i)) % MEM_BYTES]) << (8 * i);
		end
		return v;
	endfunction

	// one tick of the port; the store lands after the fetch and the load read
	task automatic advance_port(output port_tick_t r);
		int unsigned n;
		logic        ok;
		logic        store_now;
		r = '0;
		store_now = 1'b0;
		n = 0;
		r.fetch_resp_valid = fetch_valid;
		if (fetch_valid && fits_in_memory(fetch_address, 4)) begin
			r.fetch_ok   = 1'b1;
			r.fetch_word = read_bytes(fetch_address, 4);
		end
		if (in_flight) begin
			if (ticks_left > 1) begin
				ticks_left--;
			end else begin
				n  = access_bytes(pending_req.size);
				ok = (n != 0) && fits_in_memory(pending_req.address, n);
				r.resp_valid    = 1'b1;
				r.resp_tag      = pending_req.tag;
				r.resp_is_store = pending_req.st_op;
				r.resp_ok       = ok;
				if (!pending_req.st_op) begin
					if (ok)
						r.resp_load_data = read_bytes(pending_req.address, n);
				end else if (ok) begin
					store_now = 1'b1;
				end
				in_flight  = 1'b0;
				ticks_left = 0;
			end
		end else if (req_valid && req_tag_valid) begin
			pending_req.tag        = req_tag;
			pending_req.st_op      = req_is_store;
			pending_req.size       = req_size;
			pending_req.address    = req_address;
			pending_req.store_data = req_store_data;
			in_flight  = 1'b1;
			ticks_left = LATENCY & 15;
			r.accepted = 1'b1;
		end
		if (store_now) begin
			for (int unsigned i = 0; i < n; i++)
				mem_image[(pending_req.address + ADDR_W'(i)) % MEM_BYTES] =
					pending_req.store_data[8*i +: 8];
		end
		r.port_free = !in_flight;
	endtask

	task automatic check_field(input string field, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		port_tick_t want;
		port_tick_t predicted;
		if (!arst_n) begin
			for (int i = 0; i < MEM_BYTES; i++)
				mem_image[i] = 8'h00;
			in_flight   = 1'b0;
			ticks_left  = 0;
			pending_req = '0;
			expected_ticks.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (expected_ticks.size() == 0) begin
					$error("result strobe with no transaction waiting");
					mismatches++;
				end else begin
					want = expected_ticks.pop_front();
					check_field("accepted", DATA_W'(want.accepted), DATA_W'(accepted));
					check_field("port_free", DATA_W'(want.port_free), DATA_W'(port_free));
					check_field("resp_valid", DATA_W'(want.resp_valid), DATA_W'(resp_valid));
					check_field("resp_tag", DATA_W'(want.resp_tag), DATA_W'(resp_tag));
					check_field("resp_is_store", DATA_W'(want.resp_is_store),
						DATA_W'(resp_is_store));
					check_field("resp_ok", DATA_W'(want.resp_ok), DATA_W'(resp_ok));
					check_field("resp_load_data", want.resp_load_data, resp_load_data);
					check_field("fetch_resp_valid", DATA_W'(want.fetch_resp_valid),
						DATA_W'(fetch_resp_valid));
					check_field("fetch_ok", DATA_W'(want.fetch_ok), DATA_W'(fetch_ok));
					check_field("fetch_word", want.fetch_word, fetch_word);
				end
			end
			if (start && !busy) begin
				advance_port(predicted);
				expected_ticks.push_back(predicted);
			end
			outstanding = expected_ticks.size();
		end
	end

endmodule

// ===== verif/tb_fixed_latency_data_memory_port.sv =====
`timescale 1ns / 100ps

module tb_fixed_latency_data_memory_port;
	import fldmp_pkg::*;

	localparam int MEM_BYTES   = 65536;
	localparam int LATENCY     = 2;
	localparam int N_RANDOM    = 1350;
	// no idle bursts in the last stretch of the random part
	localparam int QUIET_TAIL  = 200;
	// covers the clearing sweep of all MEM_BYTES/4 rows after reset, with margin
	localparam int STALL_LIMIT = 60000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              fetch_valid = 1'b0;
	logic [ADDR_W-1:0] fetch_address = '0;
	logic              req_valid = 1'b0;
	logic              req_tag_valid = 1'b0;
	logic [TAG_W-1:0]  req_tag = '0;
	logic              req_is_store = 1'b0;
	logic [SIZE_W-1:0] req_size = SIZE_BYTE;
	logic [ADDR_W-1:0] req_address = '0;
	logic [DATA_W-1:0] req_store_data = '0;
	logic              done;
	logic              accepted;
	logic              port_free;
	logic              resp_valid;
	logic [TAG_W-1:0]  resp_tag;
	logic              resp_is_store;
	logic              resp_ok;
	logic [DATA_W-1:0] resp_load_data;
	logic              fetch_resp_valid;
	logic              fetch_ok;
	logic [DATA_W-1:0] fetch_word;
	int                mismatches;
	int                outstanding;
	int                stall_cycles = 0;

	always #2 clk = ~clk;

	fixed_latency_data_memory_port #(
		.MEM_BYTES(MEM_BYTES),
		.LATENCY  (LATENCY)
	) dut (.*);

	data_port_checker #(
		.MEM_BYTES(MEM_BYTES),
		.LATENCY  (LATENCY)
	) checker_i (.*);

	// watchdog: give up when no transaction has been taken for too long
	always @(posedge clk) begin
		if (start && !busy)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("fixed_latency_data_memory_port: mismatch");
			$finish;
		end
	end

	// present one tick of the port and hold it until the port takes it
	task automatic offer_tick(input logic fv, input logic [ADDR_W-1:0] fa,
			input logic rv, input logic tv, input logic [TAG_W-1:0] tag,
			input logic st, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] sd);
		start          <= 1'b1;
		fetch_valid    <= fv;
		fetch_address  <= fa;
		req_valid      <= rv;
		req_tag_valid  <= tv;
		req_tag        <= tag;
		req_is_store   <= st;
		req_size       <= sz;
		req_address    <= addr;
		req_store_data <= sd;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// a data request followed by the two ticks it stays in flight; both of
	// those also offer a request, which the port has to refuse
	task automatic data_op(input logic st, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] sd,
			input logic [TAG_W-1:0] tag, input logic [ADDR_W-1:0] fa);
		offer_tick(1'b1, fa, 1'b1, 1'b1, tag, st, sz, addr, sd);
		offer_tick(1'b1, fa, 1'b1, 1'b1, ~tag, ~st, SIZE_WORD, fa, ~sd);
		offer_tick(1'b0, fa, 1'b1, 1'b1, tag ^ 8'h5a, st, sz, addr, sd);
	endtask

	// mostly a small window so loads and fetches hit earlier stores,
	// then the top edge of memory, anywhere inside, and anywhere at all
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			return ADDR_W'($urandom_range(0, 63));
		else if (sel < 15)
			return ADDR_W'(MEM_BYTES - $urandom_range(1, 8));
		else if (sel < 17)
			return ADDR_W'($urandom_range(0, MEM_BYTES - 1));
		return $urandom;
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			return SIZE_BYTE;
		else if (sel < 6)
			return SIZE_HALF;
		else if (sel < 9)
			return SIZE_WORD;
		return SIZE_BAD;
	endfunction

	initial begin
		// reset once; the port then clears memory while busy is high
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: word store of all ones, then an unaligned half load over it
		data_op(1'b1, SIZE_WORD, '0, 32'hffff_ffff, 8'h00, '0);
		data_op(1'b0, SIZE_HALF, 32'd1, '0, 8'hff, '0);
		// byte store into the last byte, word load of the last word
		data_op(1'b1, SIZE_BYTE, ADDR_W'(MEM_BYTES - 1), 32'h0000_00a5, 8'h3c,
			ADDR_W'(MEM_BYTES - 4));
		data_op(1'b0, SIZE_WORD, ADDR_W'(MEM_BYTES - 4), '0, 8'hc3,
			ADDR_W'(MEM_BYTES - 3));
		// loads and stores running past the end, fetch beyond the end
		data_op(1'b0, SIZE_WORD, ADDR_W'(MEM_BYTES - 3), '0, 8'h81, 32'hffff_fffc);
		data_op(1'b1, SIZE_WORD, ADDR_W'(MEM_BYTES - 2), 32'h1234_5678, 8'h42, '0);
		data_op(1'b0, SIZE_BYTE, 32'hffff_ffff, '0, 8'h7e, 32'd2);
		// invalid size: fails and leaves memory alone
		data_op(1'b1, SIZE_BAD, '0, 32'h1234_5678, 8'h18, '0);
		// request without a valid tag, and a tag without a request, while idle
		offer_tick(1'b1, '0, 1'b1, 1'b0, 8'h99, 1'b0, SIZE_WORD, '0, '0);
		offer_tick(1'b1, '0, 1'b0, 1'b1, 8'h66, 1'b0, SIZE_WORD, '0, '0);

		// random traffic with idle bursts, none in the tail
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i < N_RANDOM - QUIET_TAIL && $urandom_range(0, 7) == 0)
				idle_for($urandom_range(1, 12));
			offer_tick($urandom_range(0, 3) != 0, pick_address(),
				$urandom_range(0, 7) != 0, $urandom_range(0, 9) != 0,
				TAG_W'($urandom), 1'($urandom), pick_size(), pick_address(),
				$urandom);
		end
		start <= 1'b0;

		// drain: every prediction matched by a result strobe, then settle
		while (outstanding != 0) @(posedge clk);
		repeat (4 * (LATENCY + 2)) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("fixed_latency_data_memory_port: match");
		end else begin
			$display("fixed_latency_data_memory_port: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/fldmp_pkg.sv
hw/rtl/fldmp_bank.sv
hw/rtl/fldmp_ctrl.sv
hw/rtl/fixed_latency_data_memory_port.sv
hw/rtl/fldmp_chk.sv
verif/data_port_checker.sv
verif/tb_fixed_latency_data_memory_port.sv
